>>> sv/ppm_pkg.sv
// Shared constants, types, prime table and rotate helper for the prime product mixer.
package ppm_pkg;

    localparam int ROUNDS    = 64;
    localparam int ROUND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int ROM_DEPTH = 128;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int SRC_ROT   = 13;

    typedef logic [63:0] word_t;

    // Control from the top level into the round engine.
    typedef struct packed {
        logic start;
    } core_ctrl_t;

    // Status from the round engine back to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    localparam word_t PRIME_ROM [ROM_DEPTH] = '{
        64'd2985113428254948959, 64'd2133371973447287789,
        64'd9566925003104080411, 64'd6083414080430737261,
        64'd3191658566037706763, 64'd6913367267901031997,
        64'd3051762490125913007, 64'd4496279044463191703,
        64'd2879325911889076339, 64'd1685450054146532617,
        64'd3665492224534333199, 64'd5457405118009752311,
        64'd9603674174905975319, 64'd5115570615370213399,
        64'd2085406057152991381, 64'd3944123521248288751,
        64'd7068318273059084621, 64'd9757209530458778617,
        64'd4605875306346355289, 64'd6173263078309968247,
        64'd7762991333463966857, 64'd9020426977113888977,
        64'd7479023155365493211, 64'd1106308364738794853,
        64'd6407388572493574733, 64'd2575377960084637447,
        64'd3570804859728957167, 64'd9744215084471400349,
        64'd5786617550671126231, 64'd3349473746601511027,
        64'd4095923646587284861, 64'd9337574612835542873,
        64'd3860411135543820653, 64'd6490253556739218821,
        64'd8764900392399904901, 64'd3339372363887497583,
        64'd6577701767928311429, 64'd9172672799009443051,
        64'd2788564470716716463, 64'd7776210437768060567,
        64'd9071396938031495159, 64'd5357072389526583433,
        64'd6633238451589839561, 64'd6234713344370965483,
        64'd1756087432259377561, 64'd3210111471103586737,
        64'd2408295824875360559, 64'd8027800137025286071,
        64'd1345382896972678691, 64'd9079595888451204607,
        64'd6556450002823963531, 64'd7301373103704944939,
        64'd1213337252585919101, 64'd8574942160927332881,
        64'd8566185364500201241, 64'd6910045784078487233,
        64'd2298581249625702883, 64'd2596136803677419831,
        64'd8990581036371057601, 64'd3046889204803159003,
        64'd6864701819024214703, 64'd9142639517683050829,
        64'd3257525145999184439, 64'd5916350576516314903,
        64'd1991008946812235681, 64'd5221054210441722691,
        64'd4658950185140640559, 64'd7616154792906075869,
        64'd3789735489826889479, 64'd6040491638497194979,
        64'd4531551599015040559, 64'd8347022247974757701,
        64'd5867558032219360441, 64'd4346307676337591453,
        64'd1905346606445378533, 64'd7219759323757378847,
        64'd8561163821217102983, 64'd6227762971465314193,
        64'd1778354250598502561, 64'd5435722899178511549,
        64'd7859180386742822047, 64'd3610133528213982527,
        64'd4577787558750808879, 64'd3974497005134013109,
        64'd3241288686894948329, 64'd3206546850542044487,
        64'd2621128575668534623, 64'd6945339563322422683,
        64'd2086055779082649859, 64'd9237096783908108657,
        64'd1916568609042647407, 64'd8362781431934621017,
        64'd6122543372115730003, 64'd6200399818195771541,
        64'd1259180073496439959, 64'd4347405785030416513,
        64'd4385862544209720253, 64'd5836562284002027449,
        64'd3121678407354608831, 64'd4319136453194505203,
        64'd9085838656424873461, 64'd5448516463713100871,
        64'd4520015808866767003, 64'd2892328915328607301,
        64'd3897908110284010777, 64'd6252018905800065119,
        64'd3278710975885668139, 64'd2623408458547857527,
        64'd3055342605008846819, 64'd5255646576194862401,
        64'd5611094629836787733, 64'd3296996236992951511,
        64'd3283558997806116761, 64'd2823396471863459119,
        64'd9572308265712226037, 64'd8290430615658140401,
        64'd2621246478142939039, 64'd1300291691995934101,
        64'd1143863624227711889, 64'd6789671898597272039,
        64'd1593529243588418053, 64'd6573565795099723367,
        64'd7154224095543629129, 64'd2355509713379653547,
        64'd7691022839137400143, 64'd2727794217173953619,
        64'd8541344794240933387, 64'd6490328854741497349
    };

    // Rotate left; an amount of zero returns the word unchanged.
    function automatic word_t rotl64(input word_t value, input logic [5:0] amount);
        logic [127:0] wide;
        wide = {value, value} << amount;
        return wide[127:64];
    endfunction

endpackage

>>> sv/prime_product_mixer64.sv
// Top level of the prime product mixer: handshakes, result register and the round engine.
//
//  Channel   Direction  Ports                                  Carries
//  s_        in         s_valid s_ready s_source_word s_sink_word  one word pair
//  m_        out        m_valid m_ready m_new_source m_new_sink    one mixed pair
//
// One transaction runs from acceptance to m_valid through 64 rounds, each made of
// a step to rotate and fetch the prime, then three passes through the shared 32x32
// multiplier, then the accumulate step; then the result register is loaded.
// The engine flags completion at the edge of its last accumulate step.
// s_ready comes back together with m_valid, so transactions never overlap in the engine.
// The shared multiplier is why a round has three multiply passes: the 64-bit product
// modulo 2^64 is formed from three 32x32 partial products, one per cycle.
// Reset is synchronous and active low; it clears both sequencers, the engine's done flag and m_valid.
// s_ready is high only while the engine is idle. A finished result waits in the
// result register, so a new transaction is taken while m_ready is held low; if a
// second result finishes before the first is taken, the engine holds it.
module prime_product_mixer64 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_source_word,
    input  logic [63:0] s_sink_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_new_source,
    output logic [63:0] m_new_sink
);

    // Top-level sequencer: waiting for input, rounds running, result held in the engine.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    ppm_pkg::word_t      out_src_reg, out_src_next;
    ppm_pkg::word_t      out_snk_reg, out_snk_next;

    ppm_pkg::core_ctrl_t core_ctrl;
    ppm_pkg::core_stat_t core_stat;
    ppm_pkg::word_t      core_src;
    ppm_pkg::word_t      core_snk;

    logic                s_take;
    logic                out_free;
    logic                load_out;

    assign s_ready         = (state_reg == ST_IDLE);
    assign s_take          = s_valid && s_ready;
    assign core_ctrl.start = s_take;

    // The result register can be refilled when it is empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    ppm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (core_ctrl),
        .source_word (s_source_word),
        .sink_word   (s_sink_word),
        .stat        (core_stat),
        .new_source  (core_src),
        .new_sink    (core_snk)
    );

    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (core_stat.done) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                // The engine is idle here, so its result words stay put.
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        out_src_next = out_src_reg;
        out_snk_next = out_snk_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            out_src_next = core_src;
            out_snk_next = core_snk;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        out_src_reg <= out_src_next;
        out_snk_reg <= out_snk_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_new_source = out_src_reg;
    assign m_new_sink   = out_snk_reg;

    // The engine may only report completion for a transaction the top level started.
    a_done_in_run : assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.done |-> (state_reg == ST_RUN))
        else $error("round engine finished outside a running transaction");

    // An accepted transaction must set the engine going on the next cycle.
    a_start_runs : assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |=> (core_stat.busy && (state_reg == ST_RUN)))
        else $error("accepted transaction did not start the round engine");

    // A result is only parked in the engine while the result register is occupied.
    a_hold_full : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> (m_valid_reg && !core_stat.busy))
        else $error("held result without a full result register or with a busy engine");

endmodule

>>> sv/ppm_core.sv
// Round engine: sequencer plus one shared 32x32 multiplier that builds each 64-bit product.
module ppm_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  ppm_pkg::core_ctrl_t ctrl,
    input  ppm_pkg::word_t      source_word,
    input  ppm_pkg::word_t      sink_word,
    output ppm_pkg::core_stat_t stat,
    output ppm_pkg::word_t      new_source,
    output ppm_pkg::word_t      new_sink
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_ROT  = 3'd1;
    localparam logic [2:0] PH_M0   = 3'd2;
    localparam logic [2:0] PH_M1   = 3'd3;
    localparam logic [2:0] PH_M2   = 3'd4;
    localparam logic [2:0] PH_ACC  = 3'd5;

    logic [2:0]                   phase_reg, phase_next;
    logic [ppm_pkg::ROUND_W-1:0]  round_reg, round_next;
    logic                         done_reg, done_next;
    ppm_pkg::word_t               src_reg, src_next;
    ppm_pkg::word_t               snk_reg, snk_next;
    ppm_pkg::word_t               acc_reg, acc_next;
    ppm_pkg::word_t               prime_reg, prime_next;
    logic [63:0]                  prod_reg, prod_next;
    logic [31:0]                  cross_reg, cross_next;

    logic [31:0]                  mul_a, mul_b;
    logic [63:0]                  mul_p;
    ppm_pkg::word_t               src_rot;
    ppm_pkg::word_t               acc_new;
    logic [ppm_pkg::ROM_AW-1:0]   rom_idx;
    logic                         last_round;

    // The shared multiplier; its operands are steered by the phase.
    always_comb begin
        unique case (phase_reg)
            PH_M1: begin
                mul_a = acc_reg[31:0];
                mul_b = prime_reg[63:32];
            end
            PH_M2: begin
                mul_a = acc_reg[63:32];
                mul_b = prime_reg[31:0];
            end
            default: begin
                mul_a = acc_reg[31:0];
                mul_b = prime_reg[31:0];
            end
        endcase
    end

    assign mul_p      = mul_a * mul_b;
    assign src_rot    = ppm_pkg::rotl64(src_reg, 6'(ppm_pkg::SRC_ROT));
    assign rom_idx    = ppm_pkg::ROM_AW'({round_reg, src_rot[0]});
    assign acc_new    = {prod_reg[63:32] + cross_reg, prod_reg[31:0]};
    assign last_round = (round_reg == ppm_pkg::ROUND_W'(ppm_pkg::ROUNDS - 1));

    always_comb begin
        phase_next = phase_reg;
        round_next = round_reg;
        done_next  = 1'b0;
        src_next   = src_reg;
        snk_next   = snk_reg;
        acc_next   = acc_reg;
        prime_next = prime_reg;
        prod_next  = prod_reg;
        cross_next = cross_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (ctrl.start) begin
                    src_next   = source_word;
                    snk_next   = sink_word;
                    acc_next   = 64'd1;
                    round_next = '0;
                    phase_next = PH_ROT;
                end
            end
            PH_ROT: begin
                src_next   = src_rot;
                acc_next   = ppm_pkg::rotl64(acc_reg, 6'(round_reg));
                prime_next = ppm_pkg::PRIME_ROM[rom_idx];
                phase_next = PH_M0;
            end
            PH_M0: begin
                prod_next  = mul_p;
                phase_next = PH_M1;
            end
            PH_M1: begin
                cross_next = mul_p[31:0];
                phase_next = PH_M2;
            end
            PH_M2: begin
                cross_next = cross_reg + mul_p[31:0];
                phase_next = PH_ACC;
            end
            PH_ACC: begin
                acc_next = acc_new;
                if (last_round) begin
                    snk_next   = (snk_reg + (acc_new ^ src_reg)) ^ acc_new;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    snk_next   = snk_reg + (acc_new ^ src_reg);
                    round_next = round_reg + 1'b1;
                    phase_next = PH_ROT;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            round_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            round_reg <= round_next;
            done_reg  <= done_next;
        end
        src_reg   <= src_next;
        snk_reg   <= snk_next;
        acc_reg   <= acc_next;
        prime_reg <= prime_next;
        prod_reg  <= prod_next;
        cross_reg <= cross_next;
    end

    assign stat.busy  = (phase_reg != PH_IDLE);
    assign stat.done  = done_reg;
    assign new_source = src_reg;
    assign new_sink   = snk_reg;

endmodule
